// ===== design/sdqr_pkg.sv =====
`default_nettype none

package sdqr_pkg;

  // Operand and result width.
  localparam int DATA_WIDTH = 32;
  // Bits needed to count the quotient steps.
  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;
  } sdqr_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic signed [DATA_WIDTH-1:0] remainder;
    logic                         divide_by_zero;
  } sdqr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } sdqr_state_t;

endpackage

`default_nettype wire

// ===== design/signed_divider_quotient_remainder_top.sv =====
`default_nettype none

// Signed integer divider, truncating toward zero.
//
// An item (a signed dividend and divisor) is taken on operands at a rising
// clock edge where start is high and busy is low. The block then raises busy
// and works out the quotient, rounded toward zero, and the remainder, which
// carries the sign of the dividend. A zero divisor gives zero for both and
// sets divide_by_zero. The most negative value divided by minus one wraps to
// the most negative value with a zero remainder.
//
// At acceptance the operands are turned into unsigned magnitudes. A radix-2
// restoring loop then shifts one dividend bit into the partial remainder each
// cycle and shifts one quotient bit in, one subtract and compare per step and
// one step per dividend bit. State ST_FIX then applies the signs. The result
// is registered out of ST_FIX and shows on result with done high for exactly
// one cycle; busy falls in that same cycle, so a new item may be accepted
// while the result is presented.
// The receiver cannot stall the block: each result must be taken on the
// cycle that done is high. A synchronous reset returns the block to idle and
// drops done; no item in flight survives it.
module signed_divider_quotient_remainder_top (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  sdqr_pkg::sdqr_in_t  operands,
  output logic                busy,
  output logic                done,
  output sdqr_pkg::sdqr_out_t result
);

  import sdqr_pkg::*;

  sdqr_state_t state;
  sdqr_state_t state_next;

  // Dividend magnitude; quotient bits are shifted in from the bottom as the
  // dividend bits are shifted out of the top.
  logic [DATA_WIDTH-1:0] n_sh;
  logic [DATA_WIDTH-1:0] r;
  logic [DATA_WIDTH-1:0] d_mag;
  logic                  q_neg;
  logic                  r_neg;
  logic                  dbz;
  logic [CNT_W-1:0]      cnt;

  logic                  accept;
  logic                  last_step;
  logic [DATA_WIDTH-1:0] a_raw;
  logic [DATA_WIDTH-1:0] b_raw;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic [DATA_WIDTH-1:0] r_shift;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] q_fix;
  logic [DATA_WIDTH-1:0] r_fix;

  assign accept    = start && !busy;
  assign last_step = (cnt == CNT_W'(DATA_WIDTH - 1));

  // Magnitudes of the incoming operands; the most negative value maps to
  // exactly 2^(DATA_WIDTH-1), which fits as an unsigned number.
  assign a_raw = operands.dividend;
  assign b_raw = operands.divisor;
  assign a_mag = a_raw[DATA_WIDTH-1] ? (~a_raw + DATA_WIDTH'(1)) : a_raw;
  assign b_mag = b_raw[DATA_WIDTH-1] ? (~b_raw + DATA_WIDTH'(1)) : b_raw;

  // One restoring step. For a nonzero divisor the partial remainder stays
  // below the divisor magnitude, so its top bit is always clear and may be shifted out.
  assign r_shift = {r[DATA_WIDTH-2:0], n_sh[DATA_WIDTH-1]};
  assign diff    = {1'b0, r_shift} - {1'b0, d_mag};
  assign ge      = !diff[DATA_WIDTH];

  // Sign correction. A zero remainder negates to zero, so it stays plain.
  assign q_fix = q_neg ? (~n_sh + DATA_WIDTH'(1)) : n_sh;
  assign r_fix = r_neg ? (~r + DATA_WIDTH'(1)) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (state == ST_FIX);
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      n_sh  <= a_mag;
      d_mag <= b_mag;
      r     <= '0;
      q_neg <= a_raw[DATA_WIDTH-1] ^ b_raw[DATA_WIDTH-1];
      r_neg <= a_raw[DATA_WIDTH-1];
      dbz   <= (b_raw == '0);
    end else if (state == ST_RUN) begin
      r    <= ge ? diff[DATA_WIDTH-1:0] : r_shift;
      n_sh <= {n_sh[DATA_WIDTH-2:0], ge};
    end
    if (state == ST_FIX) begin
      result.quotient       <= dbz ? '0 : q_fix;
      result.remainder      <= dbz ? '0 : r_fix;
      result.divide_by_zero <= dbz;
    end
  end

`ifndef SYNTHESIS
  // A result is only presented once the divider has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while the divider is still busy");

  // An accepted item keeps the divider busy on the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the divider busy");

  // A zero divisor always yields zero quotient and remainder.
  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.divide_by_zero) |->
      (result.quotient == '0 && result.remainder == '0))
    else $error("divide by zero gave non-zero results");

  // The result strobe comes in the same cycle that busy falls.
  a_done_fell: assert property (@(posedge clk) disable iff (rst)
    done |-> $fell(busy))
    else $error("done not aligned with the fall of busy");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the signed divider. Each item carries a dividend and a
// divisor; the block answers every item with exactly one result, a strobed
// quotient, remainder and divide-by-zero flag. Every accepted item is run
// through a local restoring divider and the answer is queued. Each strobed
// result is then compared field by field with the oldest queued answer.
module tb;
  import sdqr_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  sdqr_in_t operands = '0;
  logic busy;
  logic done;
  sdqr_out_t result;

  // Answers still owed by the block, oldest first.
  sdqr_out_t pending_answers[$];
  int error_count = 0;

  signed_divider_quotient_remainder_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Truncating signed division done the long way: both operands become
  // unsigned magnitudes, one quotient bit is found per step from the top
  // down, and the signs are put back at the end. The most negative value
  // has an exact magnitude in W unsigned bits, so nothing overflows here;
  // the most negative value over minus one simply wraps when re-signed.
  function automatic sdqr_out_t divide_trunc(sdqr_in_t item);
    logic [W-1:0] n_mag;
    logic [W-1:0] d_mag;
    logic [W-1:0] quo;
    logic [W:0] part;
    logic n_neg;
    logic d_neg;
    sdqr_out_t answer;
    n_neg = item.dividend[W-1];
    d_neg = item.divisor[W-1];
    n_mag = item.dividend;
    d_mag = item.divisor;
    if (n_neg) n_mag = ~n_mag + W'(1);
    if (d_neg) d_mag = ~d_mag + W'(1);
    answer = '0;
    if (d_mag == '0) begin
      answer.divide_by_zero = 1'b1;
      return answer;
    end
    quo = '0;
    part = '0;
    for (int i = W - 1; i >= 0; i--) begin
      part = {part[W-1:0], n_mag[i]};
      quo = {quo[W-2:0], 1'b0};
      if (part >= {1'b0, d_mag}) begin
        part = part - {1'b0, d_mag};
        quo[0] = 1'b1;
      end
    end
    // A zero remainder stays plain zero, as negating zero gives zero.
    answer.quotient = (n_neg ^ d_neg) ? ~quo + W'(1) : quo;
    answer.remainder = n_neg ? ~part[W-1:0] + W'(1) : part[W-1:0];
    return answer;
  endfunction

  // Offers one item and returns at the edge that accepts it. Start is left
  // high, so that a following item can be offered with no gap; whoever
  // wants a gap lowers it.
  task automatic send_division(input logic [W-1:0] num, input logic [W-1:0] den);
    sdqr_in_t item;
    item.dividend = num;
    item.divisor = den;
    start <= 1'b1;
    operands <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(divide_trunc(item));
  endtask

  // An operand drawn from a spread of shapes: full width, shortened
  // magnitudes of either sign, small numbers and the awkward corner values.
  function automatic logic [W-1:0] rand_operand();
    logic [63:0] raw;
    logic [W-1:0] v;
    raw = {$urandom, $urandom};
    v = raw[W-1:0];
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4: begin
        v = v >> $urandom_range(0, W - 1);
        if ($urandom_range(0, 1)) v = ~v + W'(1);
      end
      5: begin
        v = W'($urandom_range(0, 16));
        if ($urandom_range(0, 1)) v = ~v + W'(1);
      end
      6: v = MOST_NEG;
      7: v = MOST_POS;
      8: v = '0;
      default: v = MINUS_ONE;
    endcase
    return v;
  endfunction

  // Corner cases first: zero divisors, the most negative value over minus
  // one, every sign combination, exact divisions with negative operands and
  // the largest and smallest magnitudes. Items go in back to back.
  task automatic test_directed_corners();
    send_division('0, '0);
    send_division(W'(5), '0);
    send_division(MOST_NEG, '0);
    send_division(MOST_POS, '0);
    send_division(MOST_NEG, MINUS_ONE);
    send_division(MOST_NEG, W'(1));
    send_division(MOST_NEG, MOST_NEG);
    send_division(MOST_NEG, MOST_POS);
    send_division(MOST_NEG, W'(2));
    send_division(MOST_POS, MOST_NEG);
    send_division(MOST_POS, MINUS_ONE);
    send_division(MOST_POS, MOST_POS);
    send_division(MOST_POS, W'(1));
    send_division(W'(7), W'(2));
    send_division(-W'(7), W'(2));
    send_division(W'(7), -W'(2));
    send_division(-W'(7), -W'(2));
    send_division(-W'(6), W'(3));
    send_division(W'(1), MOST_POS);
    send_division(MINUS_ONE, MOST_NEG);
    send_division(MINUS_ONE, MINUS_ONE);
    send_division('0, -W'(5));
    send_division('0, MOST_NEG);
  endtask

  // Random items. Between items the sender goes quiet with the given chance
  // per item; its gaps run from one cycle to beyond the block's whole run,
  // so that the next item is offered at every point of the division.
  task automatic test_random_divisions(input int count, input int idle_pct);
    int gap;
    for (int k = 0; k < count; k++) begin
      send_division(rand_operand(), rand_operand());
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 45);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The sender holds back until every owed answer has come, then carries on
  // with a short burst, so that an item also arrives at a fully idle block.
  task automatic test_drain_pause();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    test_random_divisions(8, 0);
  endtask

  // The receiver cannot hold results off, so each strobe is taken at the
  // edge that ends its cycle and checked at once.
  always @(posedge clk) begin
    sdqr_out_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no item outstanding: q=%0d r=%0d dz=%0b",
                 $time, result.quotient, result.remainder, result.divide_by_zero);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (result.quotient !== want.quotient) begin
          $display("%0t: quotient expected %0d got %0d",
                   $time, want.quotient, result.quotient);
          error_count++;
        end
        if (result.remainder !== want.remainder) begin
          $display("%0t: remainder expected %0d got %0d",
                   $time, want.remainder, result.remainder);
          error_count++;
        end
        if (result.divide_by_zero !== want.divide_by_zero) begin
          $display("%0t: divide_by_zero expected %0b got %0b",
                   $time, want.divide_by_zero, result.divide_by_zero);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    // Phases: flat out, a mostly quiet sender, a lightly quiet sender, and
    // a final flat-out stretch with a full drain part way through.
    test_random_divisions(280, 0);
    test_random_divisions(280, 77);
    test_random_divisions(280, 11);
    test_drain_pause();
    test_random_divisions(272, 0);

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // A stray strobe after the last answer would be caught in this window.
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("[signed_divider_quotient_remainder_top] OK");
    end else begin
      $display("[signed_divider_quotient_remainder_top] ERROR");
    end
    $finish;
  end

  // The slowest correct run is well under a millisecond of simulated time.
  initial begin
    #5_000_000;
    $display("[signed_divider_quotient_remainder_top] ERROR");
    $finish;
  end

endmodule
